FILE: src/aesd_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and byte functions of the AES block decryptor.
// No dependencies; aesd_round and aes_block_decrypt import this package.
package aesd_pkg;

	// Lowest round count that the core runs with (AES-128).
	localparam int unsigned MIN_ROUNDS = 10;

	localparam int unsigned BLOCK_BYTES = 16;
	localparam int unsigned BLOCK_W = 8 * BLOCK_BYTES;

	// Element 0 is byte 0 of the block, which sits in the most significant bits.
	typedef logic [0:BLOCK_BYTES-1][7:0] block_t;

	localparam logic [7:0] INV_SBOX [256] = '{
		8'h52, 8'h09, 8'h6a, 8'hd5, 8'h30, 8'h36, 8'ha5, 8'h38,
		8'hbf, 8'h40, 8'ha3, 8'h9e, 8'h81, 8'hf3, 8'hd7, 8'hfb,
		8'h7c, 8'he3, 8'h39, 8'h82, 8'h9b, 8'h2f, 8'hff, 8'h87,
		8'h34, 8'h8e, 8'h43, 8'h44, 8'hc4, 8'hde, 8'he9, 8'hcb,
		8'h54, 8'h7b, 8'h94, 8'h32, 8'ha6, 8'hc2, 8'h23, 8'h3d,
		8'hee, 8'h4c, 8'h95, 8'h0b, 8'h42, 8'hfa, 8'hc3, 8'h4e,
		8'h08, 8'h2e, 8'ha1, 8'h66, 8'h28, 8'hd9, 8'h24, 8'hb2,
		8'h76, 8'h5b, 8'ha2, 8'h49, 8'h6d, 8'h8b, 8'hd1, 8'h25,
		8'h72, 8'hf8, 8'hf6, 8'h64, 8'h86, 8'h68, 8'h98, 8'h16,
		8'hd4, 8'ha4, 8'h5c, 8'hcc, 8'h5d, 8'h65, 8'hb6, 8'h92,
		8'h6c, 8'h70, 8'h48, 8'h50, 8'hfd, 8'hed, 8'hb9, 8'hda,
		8'h5e, 8'h15, 8'h46, 8'h57, 8'ha7, 8'h8d, 8'h9d, 8'h84,
		8'h90, 8'hd8, 8'hab, 8'h00, 8'h8c, 8'hbc, 8'hd3, 8'h0a,
		8'hf7, 8'he4, 8'h58, 8'h05, 8'hb8, 8'hb3, 8'h45, 8'h06,
		8'hd0, 8'h2c, 8'h1e, 8'h8f, 8'hca, 8'h3f, 8'h0f, 8'h02,
		8'hc1, 8'haf, 8'hbd, 8'h03, 8'h01, 8'h13, 8'h8a, 8'h6b,
		8'h3a, 8'h91, 8'h11, 8'h41, 8'h4f, 8'h67, 8'hdc, 8'hea,
		8'h97, 8'hf2, 8'hcf, 8'hce, 8'hf0, 8'hb4, 8'he6, 8'h73,
		8'h96, 8'hac, 8'h74, 8'h22, 8'he7, 8'had, 8'h35, 8'h85,
		8'he2, 8'hf9, 8'h37, 8'he8, 8'h1c, 8'h75, 8'hdf, 8'h6e,
		8'h47, 8'hf1, 8'h1a, 8'h71, 8'h1d, 8'h29, 8'hc5, 8'h89,
		8'h6f, 8'hb7, 8'h62, 8'h0e, 8'haa, 8'h18, 8'hbe, 8'h1b,
		8'hfc, 8'h56, 8'h3e, 8'h4b, 8'hc6, 8'hd2, 8'h79, 8'h20,
		8'h9a, 8'hdb, 8'hc0, 8'hfe, 8'h78, 8'hcd, 8'h5a, 8'hf4,
		8'h1f, 8'hdd, 8'ha8, 8'h33, 8'h88, 8'h07, 8'hc7, 8'h31,
		8'hb1, 8'h12, 8'h10, 8'h59, 8'h27, 8'h80, 8'hec, 8'h5f,
		8'h60, 8'h51, 8'h7f, 8'ha9, 8'h19, 8'hb5, 8'h4a, 8'h0d,
		8'h2d, 8'he5, 8'h7a, 8'h9f, 8'h93, 8'hc9, 8'h9c, 8'hef,
		8'ha0, 8'he0, 8'h3b, 8'h4d, 8'hae, 8'h2a, 8'hf5, 8'hb0,
		8'hc8, 8'heb, 8'hbb, 8'h3c, 8'h83, 8'h53, 8'h99, 8'h61,
		8'h17, 8'h2b, 8'h04, 8'h7e, 8'hba, 8'h77, 8'hd6, 8'h26,
		8'he1, 8'h69, 8'h14, 8'h63, 8'h55, 8'h21, 8'h0c, 8'h7d
	};

	function automatic logic [7:0] xtime(input logic [7:0] a);
		xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	// One column of InvMixColumns, byte 0 of the column in element 0.
	function automatic logic [0:3][7:0] inv_mix_col(input logic [0:3][7:0] a);
		logic [0:3][7:0] m2, m4, m8, m9, m11, m13, m14;
		logic [0:3][7:0] r;
		for (int i = 0; i < 4; i++) begin
			m2[i] = xtime(a[i]);
			m4[i] = xtime(m2[i]);
			m8[i] = xtime(m4[i]);
			m9[i] = m8[i] ^ a[i];
			m11[i] = m8[i] ^ m2[i] ^ a[i];
			m13[i] = m8[i] ^ m4[i] ^ a[i];
			m14[i] = m8[i] ^ m4[i] ^ m2[i];
		end
		r[0] = m14[0] ^ m11[1] ^ m13[2] ^ m9[3];
		r[1] = m9[0] ^ m14[1] ^ m11[2] ^ m13[3];
		r[2] = m13[0] ^ m9[1] ^ m14[2] ^ m11[3];
		r[3] = m11[0] ^ m13[1] ^ m9[2] ^ m14[3];
		return r;
	endfunction

endpackage

FILE: src/aesd_ram.sv
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module aesd_ram #(
	parameter int unsigned WIDTH = 128,
	parameter int unsigned DEPTH = 15
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

FILE: src/aesd_round.sv
`timescale 1ns / 1ps
// One AES inverse round: InvShiftRows, InvSubBytes, AddRoundKey, then InvMixColumns when mix_en is high.
// Depends on aesd_pkg for the block type, the inverse S-box and the column mix.
module aesd_round (
	input  aesd_pkg::block_t blk_in,
	input  aesd_pkg::block_t round_key,
	input  logic             mix_en,
	output aesd_pkg::block_t blk_out
);
	import aesd_pkg::*;

	block_t sub;
	block_t keyed;
	block_t mixed;

	always_comb begin
		// Byte r + 4c comes from row r of column (c - r) mod 4.
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				sub[r + 4 * c] = INV_SBOX[blk_in[r + 4 * ((c + 4 - r) % 4)]];
			end
		end
		keyed = sub ^ round_key;
		for (int c = 0; c < 4; c++) begin
			mixed[4 * c +: 4] = inv_mix_col(keyed[4 * c +: 4]);
		end
		blk_out = mix_en ? mixed : keyed;
	end

endmodule

FILE: src/aes_block_decrypt.sv
`timescale 1ns / 1ps
// Top level of the AES block decryptor: key store, round sequencer, output register.
// Depends on aesd_pkg, aesd_ram and aesd_round.
//
//  channel | direction | handshake                 | payload
//  s_*     | in        | s_tvalid / s_tready       | s_tdata: key_slot, word_hi, word_lo;
//          |           |                           | s_tuser: kind
//  m_*     | out       | m_tvalid / m_tready       | m_tdata: plain_hi, plain_lo
//  cfg_*   | in        | cfg_wr_en (no wait)       | cfg_wr_data: round_count
//
// A load item is written straight into the key store, unless its slot is past MAX_ROUNDS.
// A decrypt item keeps the core busy after it is taken: one key add, then one round
// per cycle through the single round unit, each reading one round key from the store,
// then a step to move the block to the output.
// The result then sits in the output register; the next item is taken meanwhile.
// If the previous result is still waiting, the finished block holds until it leaves.
// Reset clears control state only; key slots hold nothing defined until loaded.
module aes_block_decrypt #(
	parameter int unsigned MAX_ROUNDS = 14
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [135:0] s_tdata,      // [3:0] key_slot, [67:4] word_hi, [131:68] word_lo
	input  logic [0:0]   s_tuser,      // [0] kind
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata,      // [63:0] plain_hi, [127:64] plain_lo
	input  logic         cfg_wr_en,
	input  logic [3:0]   cfg_wr_data
);
	import aesd_pkg::*;

	localparam int unsigned AW = $clog2(MAX_ROUNDS + 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_FIRST = 2'd1;
	localparam logic [1:0] ST_ROUND = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	localparam logic KIND_LOAD = 1'b0;

	logic [1:0]    state_q;
	logic [3:0]    round_count_q;
	logic [AW-1:0] rnd_q;
	block_t        blk_q;
	logic          out_valid_q;
	logic [127:0]  out_data_q;

	logic          in_fire;
	logic          is_load;
	logic [3:0]    in_slot;
	block_t        in_blk;
	logic [AW-1:0] nr;
	logic          key_we;
	logic [AW-1:0] rd_addr;
	logic [BLOCK_W-1:0] rd_key;
	block_t        round_out;
	logic          out_free;

	assign in_fire = s_tvalid && s_tready;
	assign is_load = (s_tuser[0] == KIND_LOAD);
	assign in_slot = s_tdata[3:0];
	assign in_blk  = {s_tdata[67:4], s_tdata[131:68]};
	assign key_we  = in_fire && is_load && (in_slot <= 4'(MAX_ROUNDS));

	// Out-of-range round counts are clamped to the supported span.
	always_comb begin
		if (round_count_q < 4'(MIN_ROUNDS)) begin
			nr = AW'(MIN_ROUNDS);
		end else if (round_count_q > 4'(MAX_ROUNDS)) begin
			nr = AW'(MAX_ROUNDS);
		end else begin
			nr = AW'(round_count_q);
		end
	end

	// The store's read is registered, so the key for the next step is addressed
	// in the cycle before it is used.
	always_comb begin
		case (state_q)
			ST_IDLE:  rd_addr = nr;
			ST_FIRST: rd_addr = rnd_q;
			ST_ROUND: rd_addr = rnd_q - AW'(1);
			default:  rd_addr = rnd_q;
		endcase
	end

	aesd_ram #(
		.WIDTH(BLOCK_W),
		.DEPTH(MAX_ROUNDS + 1)
	) u_key_store (
		.clk     (clk),
		.wr_en   (key_we),
		.wr_addr (in_slot[AW-1:0]),
		.wr_data (in_blk),
		.rd_addr (rd_addr),
		.rd_data (rd_key)
	);

	aesd_round u_round (
		.blk_in    (blk_q),
		.round_key (rd_key),
		.mix_en    (rnd_q != '0),
		.blk_out   (round_out)
	);

	assign out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			round_count_q <= 4'(MIN_ROUNDS);
			rnd_q         <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				round_count_q <= cfg_wr_data;
			end
			// A finished block takes the output register as soon as it is free.
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire && !is_load) begin
						rnd_q   <= nr - AW'(1);
						state_q <= ST_FIRST;
					end
				end
				ST_FIRST: begin
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					rnd_q <= rnd_q - AW'(1);
					if (rnd_q == '0) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					blk_q <= in_blk;
				end
			end
			ST_FIRST: blk_q <= blk_q ^ block_t'(rd_key);
			ST_ROUND: blk_q <= round_out;
			default: begin
				if (out_free) begin
					out_data_q <= {blk_q[8:15], blk_q[0:7]};
				end
			end
		endcase
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

FILE: src/aesd_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the AES block decryptor, bound to the top level.
// Depends only on the ports of aes_block_decrypt.
module aesd_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic [0:0]   s_tuser,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [127:0] m_tdata
);

	// A waiting result neither disappears nor changes.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result item dropped or changed while stalled");

	// A decrypt item leaves the core busy after it is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser[0] |=> !s_tready ##1 !s_tready)
		else $error("core ready too soon after a decrypt item");

	// A key load finishes in its own cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !s_tuser[0] |=> s_tready)
		else $error("core busy after a key load");

	// A new result only appears at the end of a busy period.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result item appeared without a decrypt run");

endmodule

bind aes_block_decrypt aesd_checker u_aesd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for the AES block decryptor: loads round keys, decrypts blocks under
// several round counts and compares each plaintext against a behavioral inverse cipher.
// Depends on the aes_block_decrypt RTL only; the scoreboard builds its own S-box.
module testbench;

	localparam int unsigned MAX_ROUNDS = 14;
	localparam int unsigned NUM_SLOTS = MAX_ROUNDS + 1;
	localparam int unsigned DRAIN_CYCLES = 24;
	localparam int unsigned TAIL_CYCLES = 40;

	typedef enum logic {
		KIND_LOAD    = 1'b0,
		KIND_DECRYPT = 1'b1
	} item_kind_e;

	// Element 0 is byte 0 of the block, held in the most significant bits.
	typedef logic [0:15][7:0] state_t;

	class plain_tracker;
		logic [7:0] inv_sbox [256];
		state_t key_store [NUM_SLOTS];
		int unsigned rounds;
		logic [127:0] plain_due [$];
		int unsigned fails;

		function new();
			logic [7:0] inv, s;
			for (int x = 0; x < 256; x++) begin
				inv = 8'h00;
				if (x != 0) begin
					for (int y = 1; y < 256; y++) begin
						if (gf_mul(x[7:0], y[7:0]) == 8'h01) begin
							inv = y[7:0];
							break;
						end
					end
				end
				s = inv ^ rotl8(inv, 1) ^ rotl8(inv, 2) ^ rotl8(inv, 3) ^ rotl8(inv, 4) ^ 8'h63;
				inv_sbox[s] = x[7:0];
			end
			rounds = 10;
			fails = 0;
		endfunction

		function logic [7:0] rotl8(logic [7:0] x, int n);
			return (x << n) | (x >> (8 - n));
		endfunction

		function logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
			logic [7:0] p;
			p = 8'h00;
			for (int i = 0; i < 8; i++) begin
				if (b[0])
					p = p ^ a;
				a = a[7] ? ({a[6:0], 1'b0} ^ 8'h1b) : {a[6:0], 1'b0};
				b = b >> 1;
			end
			return p;
		endfunction

		function state_t shift_sub(state_t st);
			state_t t;
			for (int c = 0; c < 4; c++)
				for (int r = 0; r < 4; r++)
					t[r + 4 * c] = inv_sbox[st[r + 4 * ((c + 4 - r) % 4)]];
			return t;
		endfunction

		function state_t mix_columns(state_t st);
			state_t t;
			logic [7:0] a0, a1, a2, a3;
			for (int c = 0; c < 4; c++) begin
				a0 = st[4 * c];
				a1 = st[4 * c + 1];
				a2 = st[4 * c + 2];
				a3 = st[4 * c + 3];
				t[4 * c]     = gf_mul(a0, 8'd14) ^ gf_mul(a1, 8'd11) ^ gf_mul(a2, 8'd13)
					^ gf_mul(a3, 8'd9);
				t[4 * c + 1] = gf_mul(a0, 8'd9) ^ gf_mul(a1, 8'd14) ^ gf_mul(a2, 8'd11)
					^ gf_mul(a3, 8'd13);
				t[4 * c + 2] = gf_mul(a0, 8'd13) ^ gf_mul(a1, 8'd9) ^ gf_mul(a2, 8'd14)
					^ gf_mul(a3, 8'd11);
				t[4 * c + 3] = gf_mul(a0, 8'd11) ^ gf_mul(a1, 8'd13) ^ gf_mul(a2, 8'd9)
					^ gf_mul(a3, 8'd14);
			end
			return t;
		endfunction

		function state_t inv_cipher(state_t ct);
			state_t st;
			int nr;
			// Round counts outside the supported range are clamped, 11 and 13 pass as is.
			nr = (rounds < 10) ? 10 : (rounds > MAX_ROUNDS) ? MAX_ROUNDS : rounds;
			st = ct ^ key_store[nr];
			for (int r = nr - 1; r >= 1; r--)
				st = mix_columns(shift_sub(st) ^ key_store[r]);
			return shift_sub(st) ^ key_store[0];
		endfunction

		function void note_item(logic kind, logic [3:0] slot, logic [63:0] hi, logic [63:0] lo);
			if (kind == KIND_LOAD) begin
				// A load to a slot past the store is dropped.
				if (slot <= MAX_ROUNDS)
					key_store[slot] = {hi, lo};
			end else begin
				plain_due.push_back(inv_cipher({hi, lo}));
			end
		endfunction

		function void check_plain(logic [63:0] hi, logic [63:0] lo);
			logic [127:0] exp_block;
			if (plain_due.size() == 0) begin
				$error("unexpected result: plain_hi %h, plain_lo %h", hi, lo);
				fails++;
				return;
			end
			exp_block = plain_due.pop_front();
			if (hi !== exp_block[127:64]) begin
				$error("plain_hi mismatch: expected %h, actual %h", exp_block[127:64], hi);
				fails++;
			end
			if (lo !== exp_block[63:0]) begin
				$error("plain_lo mismatch: expected %h, actual %h", exp_block[63:0], lo);
				fails++;
			end
		endfunction

		function int unsigned pending();
			return plain_due.size();
		endfunction
	endclass

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [135:0] s_tdata = '0;   // [3:0] key_slot, [67:4] word_hi, [131:68] word_lo
	logic [0:0]   s_tuser = '0;   // [0] kind
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [127:0] m_tdata;        // [63:0] plain_hi, [127:64] plain_lo
	logic         cfg_wr_en = 1'b0;
	logic [3:0]   cfg_wr_data = '0;

	plain_tracker tracker;
	int unsigned tx_gap_pct;
	int unsigned rx_stall_pct;

	aes_block_decrypt #(
		.MAX_ROUNDS(MAX_ROUNDS)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always #5 clk = ~clk;

	// Mostly short gaps, now and then a long one.
	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 80)
			return $urandom_range(1, 3);
		else if (roll < 95)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic send_item(input logic kind, input logic [3:0] slot, input logic [63:0] hi,
			input logic [63:0] lo);
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {4'b0000, lo, hi, slot};
		do
			@(posedge clk);
		while (!s_tready);
		tracker.note_item(kind, slot, hi, lo);
	endtask

	task automatic hold_off(input int unsigned cycles);
		repeat (cycles) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
	endtask

	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
	endtask

	task automatic set_rounds(input logic [3:0] value);
		drain();
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		tracker.rounds = value;
	endtask

	task automatic run_phase(input int unsigned count);
		int unsigned roll;
		logic [63:0] hi, lo;
		for (int unsigned i = 0; i < count; i++) begin
			// Switch between quiet stretches and stretches with idling on either side.
			if (i % 64 == 0) begin
				tx_gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 50);
				rx_stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 50);
			end
			if (i == 90)
				drain();
			hi = {$urandom, $urandom};
			lo = {$urandom, $urandom};
			roll = $urandom_range(0, 99);
			if (roll < 4)
				send_item(KIND_DECRYPT, 4'($urandom), {64{roll[0]}}, {64{roll[1]}});
			else if (roll < 70)
				send_item(KIND_DECRYPT, 4'($urandom), hi, lo);
			else if (roll < 95)
				send_item(KIND_LOAD, 4'($urandom_range(0, MAX_ROUNDS)), hi, lo);
			else
				send_item(KIND_LOAD, 4'd15, hi, lo);
			if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct)
				hold_off(pick_gap());
		end
	endtask

	initial begin
		int unsigned stall_left;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready <= 1'b1;
				if (rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct)
					stall_left = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			tracker.check_plain(m_tdata[63:0], m_tdata[127:64]);
	end

	initial begin
		logic [3:0] round_plan [8];
		tracker = new();
		tx_gap_pct = 0;
		rx_stall_pct = 0;
		round_plan = '{4'd14, 4'd0, 4'd12, 4'd15, 4'd11, 4'd13, 4'd9, 4'd10};
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// Fill every slot before the first decrypt so no unloaded key is ever read.
		send_item(KIND_LOAD, 4'd0, {64{1'b1}}, {64{1'b1}});
		for (int s = 1; s < MAX_ROUNDS; s++)
			send_item(KIND_LOAD, s[3:0], {$urandom, $urandom}, {$urandom, $urandom});
		send_item(KIND_LOAD, 4'd14, 64'h0, 64'h0);
		// A load past the last slot must leave the store untouched.
		send_item(KIND_LOAD, 4'd15, {64{1'b1}}, {64{1'b1}});
		send_item(KIND_DECRYPT, 4'd0, 64'h0, 64'h0);
		send_item(KIND_DECRYPT, 4'd15, {64{1'b1}}, {64{1'b1}});
		send_item(KIND_DECRYPT, 4'd5, {32{2'b10}}, {32{2'b01}});
		send_item(KIND_DECRYPT, 4'd10, 64'h0011223344556677, 64'h8899aabbccddeeff);
		hold_off(3);
		send_item(KIND_DECRYPT, 4'd0, {$urandom, $urandom}, {$urandom, $urandom});

		foreach (round_plan[p]) begin
			set_rounds(round_plan[p]);
			run_phase(180);
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (tracker.fails == 0 && tracker.pending() == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("testbench: FAIL");
		$finish;
	end

endmodule

FILE: sim.f
src/aesd_pkg.sv
src/aesd_ram.sv
src/aesd_round.sv
src/aes_block_decrypt.sv
src/aesd_checker.sv
tb/testbench.sv
